FILE: sv/omlr_pkg.sv
// ----------------------------------------------------------------------------
// omlr_pkg: shared types, octant codes and step tables
// Octant numbering and the per-octant screen moves used by the line walker.
// ----------------------------------------------------------------------------
package omlr_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef logic [2:0] t_oct;

    // octant codes
    localparam t_oct OCT_0 = 3'd0;
    localparam t_oct OCT_1 = 3'd1;
    localparam t_oct OCT_2 = 3'd2;
    localparam t_oct OCT_3 = 3'd3;
    localparam t_oct OCT_4 = 3'd4;
    localparam t_oct OCT_5 = 3'd5;
    localparam t_oct OCT_6 = 3'd6;
    localparam t_oct OCT_7 = 3'd7;

    // octants whose major axis is x
    function automatic logic oct_x_major(input t_oct oct);
        return (oct == OCT_0) || (oct == OCT_3) || (oct == OCT_4) || (oct == OCT_7);
    endfunction

    // screen x move of a major step
    function automatic logic signed [1:0] major_dx(input t_oct oct);
        logic signed [1:0] d;
        case (oct)
            OCT_0, OCT_7: d = 2'sd1;
            OCT_3, OCT_4: d = -2'sd1;
            default:      d = 2'sd0;
        endcase
        return d;
    endfunction

    // screen y move of a major step
    function automatic logic signed [1:0] major_dy(input t_oct oct);
        logic signed [1:0] d;
        case (oct)
            OCT_1, OCT_2: d = 2'sd1;
            OCT_5, OCT_6: d = -2'sd1;
            default:      d = 2'sd0;
        endcase
        return d;
    endfunction

    // screen x move of a minor step
    function automatic logic signed [1:0] minor_dx(input t_oct oct);
        logic signed [1:0] d;
        case (oct)
            OCT_1, OCT_6: d = 2'sd1;
            OCT_2, OCT_5: d = -2'sd1;
            default:      d = 2'sd0;
        endcase
        return d;
    endfunction

    // screen y move of a minor step
    function automatic logic signed [1:0] minor_dy(input t_oct oct);
        logic signed [1:0] d;
        case (oct)
            OCT_0, OCT_3: d = 2'sd1;
            OCT_4, OCT_7: d = -2'sd1;
            default:      d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/omlr_setup.sv
// ----------------------------------------------------------------------------
// omlr_setup: line setup
// Picks the octant of a line from its endpoints and derives the major length,
// the initial midpoint decision and its two increments.
// ----------------------------------------------------------------------------
module omlr_setup #(
    parameter int COORD_BITS = omlr_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output omlr_pkg::t_oct               o_octant,
    output logic        [COORD_BITS-1:0] o_major,
    output logic signed [COORD_BITS+2:0] o_dec,
    output logic        [COORD_BITS:0]   o_east,
    output logic signed [COORD_BITS+2:0] o_diag
);
    import omlr_pkg::*;

    localparam int CW = COORD_BITS;

    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic signed [CW:0]   abs_x_w;
    logic signed [CW:0]   abs_y_w;
    logic        [CW-1:0] ax;
    logic        [CW-1:0] ay;
    logic                 neg_x;
    logic                 neg_y;
    logic                 le_x;
    logic                 le_y;
    logic                 x_ge;
    logic                 y_ge;
    logic        [CW-1:0] mnr;
    logic signed [CW:0]   diff;

    // endpoint deltas and magnitudes
    always_comb begin
        dx      = $signed({i_end_x[CW-1], i_end_x}) - $signed({i_start_x[CW-1], i_start_x});
        dy      = $signed({i_end_y[CW-1], i_end_y}) - $signed({i_start_y[CW-1], i_start_y});
        abs_x_w = dx[CW] ? -dx : dx;
        abs_y_w = dy[CW] ? -dy : dy;
        ax      = abs_x_w[CW-1:0];
        ay      = abs_y_w[CW-1:0];
        neg_x   = dx[CW];
        neg_y   = dy[CW];
        le_x    = neg_x || (dx == '0);
        le_y    = neg_y || (dy == '0);
        x_ge    = ax >= ay;
        y_ge    = ay >= ax;
    end

    // octant choice, first match wins
    always_comb begin
        if (x_ge && !neg_x && !neg_y) begin
            o_octant = OCT_0;
        end else if (y_ge && !neg_x && !neg_y) begin
            o_octant = OCT_1;
        end else if (y_ge && le_x && !neg_y) begin
            o_octant = OCT_2;
        end else if (x_ge && le_x && !neg_y) begin
            o_octant = OCT_3;
        end else if (x_ge && le_x && le_y) begin
            o_octant = OCT_4;
        end else if (y_ge && le_x && le_y) begin
            o_octant = OCT_5;
        end else if (y_ge && !neg_x && le_y) begin
            o_octant = OCT_6;
        end else begin
            o_octant = OCT_7;
        end
    end

    // decision variable and increments
    always_comb begin
        if (oct_x_major(o_octant)) begin
            o_major = ax;
            mnr     = ay;
        end else begin
            o_major = ay;
            mnr     = ax;
        end
        o_dec  = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, o_major});
        o_east = {mnr, 1'b0};
        diff   = $signed({1'b0, mnr}) - $signed({1'b0, o_major});
        o_diag = {diff[CW], diff, 1'b0};
    end

endmodule

FILE: sv/octant_midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// octant_midpoint_line_rasterizer: eight-zone midpoint line walker
// Path: an input transfer loads the input register, and the result register is
// loaded from it once the result channel is free (o_in_stall holds it otherwise).
// Throughput: one item per cycle while the result channel does not stall; the walk state updates in a single add step.
// Reset: synchronous active-low; clears pipeline valids and the active line.
// ----------------------------------------------------------------------------
module octant_midpoint_line_rasterizer #(
    parameter int COORD_BITS = omlr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_valid_res,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic        [2:0]            o_zone_out,
    output logic                         o_last
);
    import omlr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int EW = COORD_BITS + 1;

    // input register
    logic                  r_in_vld;
    logic                  r_op;
    logic signed [CW-1:0]  r_sx;
    logic signed [CW-1:0]  r_sy;
    logic signed [CW-1:0]  r_ex;
    logic signed [CW-1:0]  r_ey;

    // walk state
    logic                  r_active, n_active;
    logic signed [CW-1:0]  r_walk_x, n_walk_x;
    logic signed [CW-1:0]  r_walk_y, n_walk_y;
    logic        [CW-1:0]  r_walk_end, n_walk_end;
    logic signed [DW-1:0]  r_dec, n_dec;
    logic        [EW-1:0]  r_east, n_east;
    logic signed [DW-1:0]  r_diag, n_diag;
    t_oct                  r_oct, n_oct;

    // result register
    logic                  r_out_vld;
    logic                  r_res_vld, n_res_vld;
    logic signed [CW-1:0]  r_px, n_px;
    logic signed [CW-1:0]  r_py, n_py;
    t_oct                  r_zone, n_zone;
    logic                  r_last, n_last;

    // setup results
    t_oct                  su_oct;
    logic        [CW-1:0]  su_major;
    logic signed [DW-1:0]  su_dec;
    logic        [EW-1:0]  su_east;
    logic signed [DW-1:0]  su_diag;

    // handshake
    logic                  out_free;
    logic                  adv;
    logic                  in_take;

    // step terms
    logic                  go_diag;
    logic signed [1:0]     sx;
    logic signed [1:0]     sy;
    logic signed [CW-1:0]  stp_x;
    logic signed [CW-1:0]  stp_y;
    logic        [CW-1:0]  rem_end;

    omlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (r_ex),
        .i_end_y   (r_ey),
        .o_octant  (su_oct),
        .o_major   (su_major),
        .o_dec     (su_dec),
        .o_east    (su_east),
        .o_diag    (su_diag)
    );

    // flow control: compute stage fires when the result register can take it
    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // one midpoint step
    always_comb begin
        go_diag = !r_dec[DW-1];
        sx      = major_dx(r_oct) + (go_diag ? minor_dx(r_oct) : 2'sd0);
        sy      = major_dy(r_oct) + (go_diag ? minor_dy(r_oct) : 2'sd0);
        stp_x   = r_walk_x + {{(CW-2){sx[1]}}, sx};
        stp_y   = r_walk_y + {{(CW-2){sy[1]}}, sy};
        rem_end = r_walk_end - {{(CW-1){1'b0}}, 1'b1};
    end

    // next state and result
    always_comb begin
        n_active   = r_active;
        n_walk_x   = r_walk_x;
        n_walk_y   = r_walk_y;
        n_walk_end = r_walk_end;
        n_dec      = r_dec;
        n_east     = r_east;
        n_diag     = r_diag;
        n_oct      = r_oct;
        n_res_vld  = 1'b0;
        n_px       = '0;
        n_py       = '0;
        n_zone     = OCT_0;
        n_last     = 1'b0;
        if (r_op == OP_START) begin
            n_oct      = su_oct;
            n_dec      = su_dec;
            n_east     = su_east;
            n_diag     = su_diag;
            n_walk_x   = r_sx;
            n_walk_y   = r_sy;
            n_walk_end = su_major;
            n_active   = su_major != '0;
            n_res_vld  = 1'b1;
            n_px       = r_sx;
            n_py       = r_sy;
            n_zone     = su_oct;
            n_last     = su_major == '0;
        end else if (r_active) begin
            n_walk_x   = stp_x;
            n_walk_y   = stp_y;
            n_dec      = go_diag ? r_dec + r_diag
                                 : r_dec + $signed({{(DW-EW){1'b0}}, r_east});
            n_walk_end = rem_end;
            n_active   = rem_end != '0;
            n_res_vld  = 1'b1;
            n_px       = stp_x;
            n_py       = stp_y;
            n_zone     = r_oct;
            n_last     = rem_end == '0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
        if (in_take) begin
            r_op <= i_op;
            r_sx <= i_start_x;
            r_sy <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
        end
    end

    // walk state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_active  <= n_active;
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
        if (adv) begin
            r_walk_x   <= n_walk_x;
            r_walk_y   <= n_walk_y;
            r_walk_end <= n_walk_end;
            r_dec      <= n_dec;
            r_east     <= n_east;
            r_diag     <= n_diag;
            r_oct      <= n_oct;
            r_res_vld  <= n_res_vld;
            r_px       <= n_px;
            r_py       <= n_py;
            r_zone     <= n_zone;
            r_last     <= n_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_valid_res = r_res_vld;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_zone_out  = r_zone;
    assign o_last      = r_last;

`ifndef NO_ASSERTIONS
    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |->
            (o_pixel_x == '0 && o_pixel_y == '0 && o_zone_out == '0 && !o_last))
        else $error("empty result with nonzero fields");

    // the shown pixel agrees with the walk state about the line ending
    a_last_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (r_active == !o_last))
        else $error("last flag disagrees with active line");

    // an active line always has steps to go
    a_end_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_walk_end != '0))
        else $error("active line with no steps left");

    // a held input register is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_op) && $stable(r_sx)))
        else $error("input register lost a pending item");
`endif

endmodule
